### sv/confusion_matrix_metrics_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the confusion matrix metrics block
// ----------------------------------------------------------------------------
`ifndef CONFUSION_MATRIX_METRICS_DEFINES_SVH
`define CONFUSION_MATRIX_METRICS_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define CMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition is followed by a consequence in the next cycle.
`define CMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/cmm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_pkg
// Types, codes and defaults shared by the confusion matrix metrics block.
// ----------------------------------------------------------------------------
package cmm_pkg;

  localparam int MAX_CLASSES_DEF = 15;
  localparam int COUNT_BITS_DEF  = 24;
  localparam int Q16_FRAC_BITS   = 16;
  localparam logic [16:0] Q16_ONE = 17'h10000;
  localparam logic [3:0]  NUM_CLASSES_RST = 4'd15;

  localparam logic [1:0] ACT_RECORD  = 2'd0;
  localparam logic [1:0] ACT_COMPUTE = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  localparam logic [2:0] MET_RATE     = 3'd0;
  localparam logic [2:0] MET_MAC_PREC = 3'd1;
  localparam logic [2:0] MET_MAC_REC  = 3'd2;
  localparam logic [2:0] MET_MAC_F1   = 3'd3;
  localparam logic [2:0] MET_MIC_PREC = 3'd4;
  localparam logic [2:0] MET_MIC_REC  = 3'd5;
  localparam logic [2:0] MET_MIC_F1   = 3'd6;

  typedef struct packed {
    logic [1:0] action;
    logic [3:0] target_class;
    logic [3:0] predicted_class;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  metric_id;
    logic [16:0] metric_value;
    logic        last_metric;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_CLS_P, OP_CLS_R, OP_CLS_F, OP_RATE, OP_MAC_P, OP_MAC_R, OP_MAC_F,
    OP_MIC_P, OP_MIC_R, OP_MIC_F
  } div_op_e;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_REC_WR, ST_SCAN, ST_SCAN_END, ST_TALLY, ST_DIV, ST_WAIT
  } ctrl_state_e;

  typedef enum logic [1:0] {
    DIV_IDLE, DIV_CHECK, DIV_RUN
  } div_state_e;

  typedef struct packed {
    logic    accept;
    logic    clr_we;
    logic    rec_we;
    logic    acc_en;
    logic    acc_diag;
    logic    acc_clr;
    logic    tot_clr;
    logic    tally;
    logic    div_start;
    div_op_e op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

  function automatic div_op_e next_op(div_op_e op);
    div_op_e r;
    case (op)
      OP_CLS_P: r = OP_CLS_R;
      OP_CLS_R: r = OP_CLS_F;
      OP_CLS_F: r = OP_RATE;
      OP_RATE:  r = OP_MAC_P;
      OP_MAC_P: r = OP_MAC_R;
      OP_MAC_R: r = OP_MAC_F;
      OP_MAC_F: r = OP_MIC_P;
      OP_MIC_P: r = OP_MIC_R;
      OP_MIC_R: r = OP_MIC_F;
      default:  r = OP_CLS_P;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] metric_code(div_op_e op);
    logic [2:0] r;
    case (op)
      OP_RATE:  r = MET_RATE;
      OP_MAC_P: r = MET_MAC_PREC;
      OP_MAC_R: r = MET_MAC_REC;
      OP_MAC_F: r = MET_MAC_F1;
      OP_MIC_P: r = MET_MIC_PREC;
      OP_MIC_R: r = MET_MIC_REC;
      default:  r = MET_MIC_F1;
    endcase
    return r;
  endfunction

endpackage

### sv/confusion_matrix_metrics.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// confusion_matrix_metrics
// Confusion matrix counter with precision, recall and F1 metric readout.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake                    Payload
// -------   ---------  ---------------------------  -----------------------
// command   in         start && !busy               item_i (in_item_t)
// result    out        result_strobe_o, one cycle   result_o (out_item_t)
// config    in         cfg_valid_i && cfg_ready_o   cfg_data_i (num_classes)
//
// Record: a read-modify-write of one counter over the store's registered
// read port. Clear: one entry a cycle over all 2**(2*CW) entries
// (256 at the default size); the same sweep runs after reset with busy high.
// Compute: per class a row/column walk over indices 0..n and a tally, plus
// three divides (cut short when the denominator is zero or the ratio is one),
// then seven divides, one beat each; a divide is the
// shared one-bit-per-cycle unit (16 steps for ratios, 17+CW for macros).
// The receiver cannot stall: each beat shows for one cycle only.
// ----------------------------------------------------------------------------
module confusion_matrix_metrics import cmm_pkg::*; #(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_item_t  item_i,
  output logic      result_strobe_o,
  output out_item_t result_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [3:0] cfg_data_i
);

  // Class index width; the store is addressed as {row, column}.
  localparam int CW = $clog2(MAX_CLASSES + 1);
  // Wide sums: up to (n+1)^2 counters, doubled for the micro F1 term.
  localparam int AW = COUNT_BITS + 2 * CW + 1;
  // Per-class Q1.16 sums over up to MAX_CLASSES classes.
  localparam int SW = 17 + CW;

  cmd_t            cmd;
  sts_t            sts;
  logic [CW-1:0]   cls, idx, n;
  logic [2*CW-1:0] clr_idx;

  // Sequencer: owns the config register and all loop counters.
  cmm_ctrl #(
    .MAX_CLASSES(MAX_CLASSES),
    .CW         (CW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .action_i    (item_i.action),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cmd_o       (cmd),
    .sts_i       (sts),
    .cls_o       (cls),
    .idx_o       (idx),
    .n_o         (n),
    .clr_idx_o   (clr_idx)
  );

  // Datapath: store, accumulators and divider; it drives the result beat.
  cmm_dp #(
    .MAX_CLASSES(MAX_CLASSES),
    .COUNT_BITS (COUNT_BITS),
    .CW         (CW),
    .AW         (AW),
    .SW         (SW)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .item_i          (item_i),
    .cls_i           (cls),
    .idx_i           (idx),
    .n_i             (n),
    .clr_idx_i       (clr_idx),
    .sts_o           (sts),
    .result_strobe_o (result_strobe_o),
    .result_o        (result_o)
  );

endmodule

### sv/cmm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_div
// Restoring divider, one quotient bit per cycle: Q1.16 ratio or integer.
// ----------------------------------------------------------------------------
module cmm_div import cmm_pkg::*; #(
  parameter int AW = 33,
  parameter int SW = 21
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          int_mode_i,
  input  logic [AW-1:0] num_i,
  input  logic [AW-1:0] den_i,
  input  logic [SW-1:0] dvd_i,
  output logic          done_o,
  output logic [SW-1:0] quo_o
);

  localparam int CNTW = $clog2(SW + 1);

  div_state_e      state_q, state_d;
  logic            done_q, done_d;
  logic            mode_q;
  logic [AW-1:0]   num_q, den_q, rem_q, rem_d;
  logic [SW-1:0]   dvd_q, dvd_d, quo_q, quo_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [AW:0]     rem_sh;
  logic            ge;

  assign rem_sh = {rem_q, dvd_q[SW-1]};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DIV_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q  <= num_i;
      den_q  <= den_i;
      mode_q <= int_mode_i;
    end
    rem_q <= rem_d;
    dvd_q <= start_i ? dvd_i : dvd_d;
    quo_q <= quo_d;
    cnt_q <= cnt_d;
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    quo_d   = quo_q;
    cnt_d   = cnt_q;
    case (state_q)
      DIV_IDLE: begin
        if (start_i) state_d = DIV_CHECK;
      end
      DIV_CHECK: begin
        quo_d = '0;
        if (mode_q) begin
          rem_d   = '0;
          cnt_d   = CNTW'(SW);
          state_d = DIV_RUN;
        end else if (den_q == '0) begin
          done_d  = 1'b1;
          state_d = DIV_IDLE;
        end else if (num_q >= den_q) begin
          quo_d   = SW'(Q16_ONE);
          done_d  = 1'b1;
          state_d = DIV_IDLE;
        end else begin
          rem_d   = num_q;
          dvd_d   = '0;
          cnt_d   = CNTW'(Q16_FRAC_BITS);
          state_d = DIV_RUN;
        end
      end
      DIV_RUN: begin
        rem_d = ge ? AW'(rem_sh - {1'b0, den_q}) : rem_sh[AW-1:0];
        quo_d = {quo_q[SW-2:0], ge};
        dvd_d = {dvd_q[SW-2:0], 1'b0};
        cnt_d = cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          done_d  = 1'b1;
          state_d = DIV_IDLE;
        end
      end
      default: state_d = DIV_IDLE;
    endcase
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### sv/cmm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_dp
// Count store, row/column accumulators, metric sums and the shared divider.
// ----------------------------------------------------------------------------
module cmm_dp import cmm_pkg::*; #(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int CW          = 4,
  parameter int AW          = 33,
  parameter int SW          = 21
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          cmd_i,
  input  in_item_t      item_i,
  input  logic [CW-1:0] cls_i,
  input  logic [CW-1:0] idx_i,
  input  logic [CW-1:0] n_i,
  input  logic [2*CW-1:0] clr_idx_i,
  output sts_t          sts_o,
  output logic          result_strobe_o,
  output out_item_t     result_o
);

  localparam int DEPTH = 2 ** (2 * CW);

  logic [COUNT_BITS-1:0] mem_q [DEPTH];
  logic [COUNT_BITS-1:0] rd_a_q, rd_b_q;
  logic [2*CW-1:0]       addr_a, addr_b, rec_addr_q;
  logic                  rec_ok_q;

  logic [AW-1:0] row_q, col_q, t_q, tp_q, fp_q, fn_q, tot_q;
  logic [SW-1:0] sp_q, sr_q, sf_q;
  div_op_e       op_q;

  logic          div_int;
  logic [AW-1:0] div_num, div_den;
  logic [SW-1:0] div_dvd, quo;
  logic          done;
  logic [SW-1:0] q17;

  assign addr_a = cmd_i.accept ? {CW'(item_i.target_class), CW'(item_i.predicted_class)}
                               : {cls_i, idx_i};
  assign addr_b = {idx_i, cls_i};

  // Two registered read ports, one write port.
  always_ff @(posedge clk_i) begin
    rd_a_q <= mem_q[addr_a];
    rd_b_q <= mem_q[addr_b];
    if (cmd_i.clr_we) begin
      mem_q[clr_idx_i] <= '0;
    end else if (cmd_i.rec_we && rec_ok_q && (rd_a_q != '1)) begin
      mem_q[rec_addr_q] <= rd_a_q + COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      rec_addr_q <= addr_a;
      rec_ok_q   <= (32'(item_i.target_class) <= MAX_CLASSES) &&
                    (32'(item_i.predicted_class) <= MAX_CLASSES);
    end
  end

  // Row, column and diagonal of the current class.
  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_clr) begin
      row_q <= '0;
      col_q <= '0;
      t_q   <= '0;
    end else if (cmd_i.acc_en) begin
      row_q <= row_q + AW'(rd_a_q);
      col_q <= col_q + AW'(rd_b_q);
      if (cmd_i.acc_diag) t_q <= AW'(rd_a_q);
    end
  end

  assign q17 = SW'(quo[16:0]);

  // Global sums and per-class metric sums.
  always_ff @(posedge clk_i) begin
    if (cmd_i.tot_clr) begin
      tp_q  <= '0;
      fp_q  <= '0;
      fn_q  <= '0;
      tot_q <= '0;
      sp_q  <= '0;
      sr_q  <= '0;
      sf_q  <= '0;
    end else begin
      if (cmd_i.tally) begin
        tp_q  <= tp_q + t_q;
        fp_q  <= fp_q + (col_q - t_q);
        fn_q  <= fn_q + (row_q - t_q);
        tot_q <= tot_q + row_q;
      end
      if (done) begin
        case (op_q)
          OP_CLS_P: sp_q <= sp_q + q17;
          OP_CLS_R: sr_q <= sr_q + q17;
          OP_CLS_F: sf_q <= sf_q + q17;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) op_q <= cmd_i.op;
  end

  always_comb begin
    div_int = 1'b0;
    div_num = '0;
    div_den = '0;
    div_dvd = '0;
    case (cmd_i.op)
      OP_CLS_P: begin div_num = t_q; div_den = col_q; end
      OP_CLS_R: begin div_num = t_q; div_den = row_q; end
      OP_CLS_F: begin div_num = t_q << 1; div_den = row_q + col_q; end
      OP_RATE:  begin div_num = tp_q; div_den = tot_q; end
      OP_MAC_P: begin div_int = 1'b1; div_dvd = sp_q; div_den = AW'(n_i); end
      OP_MAC_R: begin div_int = 1'b1; div_dvd = sr_q; div_den = AW'(n_i); end
      OP_MAC_F: begin div_int = 1'b1; div_dvd = sf_q; div_den = AW'(n_i); end
      OP_MIC_P: begin div_num = tp_q; div_den = tp_q + fp_q; end
      OP_MIC_R: begin div_num = tp_q; div_den = tp_q + fn_q; end
      OP_MIC_F: begin div_num = tp_q << 1; div_den = (tp_q << 1) + fp_q + fn_q; end
      default: ;
    endcase
  end

  cmm_div #(
    .AW(AW),
    .SW(SW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .int_mode_i (div_int),
    .num_i      (div_num),
    .den_i      (div_den),
    .dvd_i      (div_dvd),
    .done_o     (done),
    .quo_o      (quo)
  );

  assign sts_o.div_done = done;

  assign result_strobe_o       = done && (op_q != OP_CLS_P) && (op_q != OP_CLS_R) &&
                                 (op_q != OP_CLS_F);
  assign result_o.metric_id    = metric_code(op_q);
  assign result_o.metric_value = quo[16:0];
  assign result_o.last_metric  = (op_q == OP_MIC_F);

endmodule

### sv/cmm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_ctrl
// Sequencer: store clearing, sample recording and the metric walk.
// ----------------------------------------------------------------------------
module cmm_ctrl import cmm_pkg::*; #(
  parameter int MAX_CLASSES = MAX_CLASSES_DEF,
  parameter int CW          = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic [1:0]      action_i,
  input  logic            cfg_valid_i,
  input  logic [3:0]      cfg_data_i,
  output logic            cfg_ready_o,
  output cmd_t            cmd_o,
  input  sts_t            sts_i,
  output logic [CW-1:0]   cls_o,
  output logic [CW-1:0]   idx_o,
  output logic [CW-1:0]   n_o,
  output logic [2*CW-1:0] clr_idx_o
);

  ctrl_state_e     state_q, state_d;
  logic [3:0]      cfg_q;
  logic [CW-1:0]   c_q, c_d, i_q, i_d;
  logic [2*CW-1:0] clr_q, clr_d;
  logic            acc_q, diag_q;
  div_op_e         op_q, op_d;
  logic [CW-1:0]   n;
  int              n_int;

  always_comb begin
    n_int = (cfg_q == 4'd0) ? 1 : int'(cfg_q);
    if (n_int > MAX_CLASSES) n_int = MAX_CLASSES;
    n = CW'(n_int);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cfg_q   <= NUM_CLASSES_RST;
      clr_q   <= '0;
      acc_q   <= 1'b0;
      diag_q  <= 1'b0;
      c_q     <= '0;
      i_q     <= '0;
      op_q    <= OP_CLS_P;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      c_q     <= c_d;
      i_q     <= i_d;
      op_q    <= op_d;
      acc_q   <= (state_q == ST_SCAN);
      diag_q  <= (state_q == ST_SCAN) && (i_q == c_q);
      if (cfg_valid_i) cfg_q <= cfg_data_i;
    end
  end

  always_comb begin
    state_d = state_q;
    c_d     = c_q;
    i_d     = i_q;
    clr_d   = clr_q;
    op_d    = op_q;
    cmd_o   = '0;
    cmd_o.op       = op_q;
    cmd_o.acc_en   = acc_q;
    cmd_o.acc_diag = diag_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        clr_d = clr_q + (2*CW)'(1);
        if (clr_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          case (action_i)
            ACT_RECORD: state_d = ST_REC_WR;
            ACT_COMPUTE: begin
              cmd_o.tot_clr = 1'b1;
              cmd_o.acc_clr = 1'b1;
              c_d     = CW'(1);
              i_d     = '0;
              state_d = ST_SCAN;
            end
            ACT_CLEAR: begin
              clr_d   = '0;
              state_d = ST_CLEAR;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_REC_WR: begin
        cmd_o.rec_we = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        i_d = i_q + CW'(1);
        if (i_q == n) state_d = ST_SCAN_END;
      end
      ST_SCAN_END: state_d = ST_TALLY;
      ST_TALLY: begin
        cmd_o.tally = 1'b1;
        op_d    = OP_CLS_P;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_start = 1'b1;
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (sts_i.div_done) begin
          if (op_q == OP_CLS_F) begin
            if (c_q == n) begin
              op_d    = OP_RATE;
              state_d = ST_DIV;
            end else begin
              c_d     = c_q + CW'(1);
              i_d     = '0;
              cmd_o.acc_clr = 1'b1;
              state_d = ST_SCAN;
            end
          end else if (op_q == OP_MIC_F) begin
            state_d = ST_IDLE;
          end else begin
            op_d    = next_op(op_q);
            state_d = ST_DIV;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign cls_o       = c_q;
  assign idx_o       = i_q;
  assign n_o         = n;
  assign clr_idx_o   = clr_q;

endmodule

### sv/cmm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmm_checker
// Port-level checks on the confusion matrix metrics block.
// ----------------------------------------------------------------------------
`include "confusion_matrix_metrics_defines.svh"

module cmm_checker import cmm_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input in_item_t  item_i,
  input logic      result_strobe_o,
  input out_item_t result_o
);

  logic last_ok, value_ok, last_beat, compute_go;

  assign last_ok    = result_o.last_metric == (result_o.metric_id == MET_MIC_F1);
  assign value_ok   = result_o.metric_value <= Q16_ONE;
  assign last_beat  = result_strobe_o && result_o.last_metric;
  assign compute_go = start && !busy && (item_i.action == ACT_COMPUTE);

  `CMM_ASSERT(a_beat_while_busy, !result_strobe_o || busy, "result beat while idle")
  `CMM_ASSERT(a_last_on_f1, !result_strobe_o || last_ok, "last flag off the final metric")
  `CMM_ASSERT(a_value_range, !result_strobe_o || value_ok, "metric above one")
  `CMM_ASSERT_NEXT(a_last_gap, last_beat, !result_strobe_o, "beat after final metric")
  `CMM_ASSERT_NEXT(a_compute_busy, compute_go, busy, "compute not taken up")

endmodule

bind confusion_matrix_metrics cmm_checker u_cmm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start           (start),
  .busy            (busy),
  .item_i          (item_i),
  .result_strobe_o (result_strobe_o),
  .result_o        (result_o)
);

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for confusion_matrix_metrics: records labelled
// samples, clears the matrix and runs metric computes under several class
// counts, predicting every metric beat and comparing it field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import cmm_pkg::*;

  localparam int NCLS     = MAX_CLASSES_DEF;
  localparam int CNT_MAX  = (1 << COUNT_BITS_DEF) - 1;
  localparam int SETTLE   = 300;    // covers a clear sweep still running
  localparam int WD_LIMIT = 40000;  // idle cycles before giving up

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  in_item_t   item_i = '0;
  logic       result_strobe_o;
  out_item_t  result_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [3:0] cfg_data_i = '0;

  // Shadow copy of the matrix and the class count register.
  int unsigned conf_cnt [NCLS+1][NCLS+1];
  logic [3:0]  class_cfg;
  out_item_t   metric_q[$];
  int          err_cnt = 0;
  int          idle_pct = 0;
  int          wd_cnt = 0;

  always #5 clk_i = ~clk_i;

  confusion_matrix_metrics dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_strobe_o(result_strobe_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i)
  );

  // floor(num * 65536 / den), saturating at one, zero for an empty denominator
  function automatic logic [16:0] q16_frac(longint unsigned num, longint unsigned den);
    longint unsigned rem;
    logic [16:0] q;
    if (den == 0) return '0;
    if (num >= den) return Q16_ONE;
    rem = num;
    q = '0;
    for (int i = 0; i < 16; i++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem = rem - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  // Queue the seven metric beats that a compute over the shadow matrix gives.
  task automatic push_metrics();
    int unsigned n;
    longint unsigned tp, fp, fn, tot, sp, sr, sf, row, col, t;
    logic [16:0] vals [7];
    out_item_t   beat;
    n = (class_cfg == 0) ? 1 : class_cfg;
    tp = 0; fp = 0; fn = 0; tot = 0; sp = 0; sr = 0; sf = 0;
    for (int c = 1; c <= n; c++) begin
      row = 0; col = 0;
      t = conf_cnt[c][c];
      for (int i = 0; i <= n; i++) begin
        row += conf_cnt[c][i];
        col += conf_cnt[i][c];
      end
      tp += t; fp += col - t; fn += row - t; tot += row;
      sp += q16_frac(t, col);
      sr += q16_frac(t, row);
      sf += q16_frac(2 * t, row + col);
    end
    vals[0] = q16_frac(tp, tot);
    vals[1] = 17'(sp / n);
    vals[2] = 17'(sr / n);
    vals[3] = 17'(sf / n);
    vals[4] = q16_frac(tp, tp + fp);
    vals[5] = q16_frac(tp, tp + fn);
    vals[6] = q16_frac(2 * tp, 2 * tp + fp + fn);
    for (int k = 0; k < 7; k++) begin
      beat.metric_id    = 3'(k);
      beat.metric_value = vals[k];
      beat.last_metric  = (k == 6);
      metric_q.push_back(beat);
    end
  endtask

  // Advance the shadow state by one accepted command.
  task automatic apply_cmd(in_item_t it);
    case (it.action)
      ACT_RECORD: begin
        if (conf_cnt[it.target_class][it.predicted_class] < CNT_MAX)
          conf_cnt[it.target_class][it.predicted_class]++;
      end
      ACT_COMPUTE: push_metrics();
      ACT_CLEAR: begin
        foreach (conf_cnt[i, j]) conf_cnt[i][j] = 0;
      end
      default: ;  // unused action code: dropped by the block
    endcase
  endtask

  // Send one command beat; hold start until busy drops, then maybe idle.
  task automatic send_cmd(logic [1:0] act, logic [3:0] tgt, logic [3:0] prd);
    in_item_t it;
    int gap;
    it.action = act;
    it.target_class = tgt;
    it.predicted_class = prd;
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    apply_cmd(it);
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 20) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      item_i <= in_item_t'($urandom);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drain all pending metrics and let any trailing clear sweep finish.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (metric_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  // Write the class count; only called with the block idle.
  task automatic write_classes(logic [3:0] val);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    class_cfg = val;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_directed();
    // Compute on the empty matrix: every denominator is zero.
    send_cmd(ACT_COMPUTE, 4'd0, 4'd0);
    // Extremes of the class fields, unlabelled row and empty column too.
    send_cmd(ACT_RECORD, 4'd0, 4'd0);
    send_cmd(ACT_RECORD, 4'd15, 4'd15);
    send_cmd(ACT_RECORD, 4'd15, 4'd0);
    send_cmd(ACT_RECORD, 4'd0, 4'd15);
    send_cmd(ACT_RECORD, 4'd1, 4'd1);
    send_cmd(ACT_RECORD, 4'd1, 4'd15);
    send_cmd(ACT_RECORD, 4'd10, 4'd5);
    send_cmd(ACT_RECORD, 4'd5, 4'd10);
    send_cmd(ACT_COMPUTE, 4'd15, 4'd15);
    // Unused action code: must leave the matrix alone and emit nothing.
    send_cmd(2'd3, 4'd7, 4'd7);
    send_cmd(ACT_COMPUTE, 4'd0, 4'd0);
    // Perfect classifier after a clear: the rate and the micro metrics reach one.
    send_cmd(ACT_CLEAR, 4'd0, 4'd0);
    send_cmd(ACT_RECORD, 4'd2, 4'd2);
    send_cmd(ACT_RECORD, 4'd3, 4'd3);
    send_cmd(ACT_COMPUTE, 4'd0, 4'd0);
    // Class count of zero acts as one; classes beyond the count drop out.
    write_classes(4'd0);
    send_cmd(ACT_RECORD, 4'd1, 4'd2);
    send_cmd(ACT_RECORD, 4'd1, 4'd1);
    send_cmd(ACT_COMPUTE, 4'd0, 4'd0);
    write_classes(4'd1);
    send_cmd(ACT_COMPUTE, 4'd0, 4'd0);
    write_classes(4'd15);
  endtask

  // Mostly records inside the active classes, some outside, rare clears.
  task automatic test_random(int items, int pct);
    int unsigned n;
    int unsigned r;
    logic [3:0] tgt, prd;
    idle_pct = pct;
    write_classes(4'($urandom));
    n = (class_cfg == 0) ? 1 : class_cfg;
    for (int k = 0; k < items; k++) begin
      r = $urandom_range(99);
      if (r < 5) begin
        send_cmd(ACT_COMPUTE, 4'($urandom), 4'($urandom));
      end else if (r < 7) begin
        send_cmd(ACT_CLEAR, 4'($urandom), 4'($urandom));
      end else if (r < 8) begin
        send_cmd(2'd3, 4'($urandom), 4'($urandom));
      end else if (r < 20) begin
        send_cmd(ACT_RECORD, 4'($urandom), 4'($urandom));
      end else begin
        tgt = 4'($urandom_range(n));
        prd = ($urandom_range(2) == 0) ? tgt : 4'($urandom_range(n));
        send_cmd(ACT_RECORD, tgt, prd);
      end
    end
    send_cmd(ACT_COMPUTE, 4'd0, 4'd0);
  endtask

  // Compare each metric beat with the oldest prediction.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && result_strobe_o) begin
      if (metric_q.size() == 0) begin
        $display("%0t: unexpected metric beat id=%0d value=%0d last=%0b", $time,
                 result_o.metric_id, result_o.metric_value, result_o.last_metric);
        err_cnt++;
      end else begin
        want = metric_q.pop_front();
        if (result_o.metric_id !== want.metric_id) begin
          $display("%0t: metric_id expected %0d actual %0d", $time,
                   want.metric_id, result_o.metric_id);
          err_cnt++;
        end
        if (result_o.metric_value !== want.metric_value) begin
          $display("%0t: metric_value (id %0d) expected %0d actual %0d", $time,
                   want.metric_id, want.metric_value, result_o.metric_value);
          err_cnt++;
        end
        if (result_o.last_metric !== want.last_metric) begin
          $display("%0t: last_metric (id %0d) expected %0b actual %0b", $time,
                   want.metric_id, want.last_metric, result_o.last_metric);
          err_cnt++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no beat moves on any channel.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_strobe_o || (cfg_valid_i && cfg_ready_o))
      wd_cnt <= 0;
    else
      wd_cnt <= wd_cnt + 1;
    if (wd_cnt >= WD_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    foreach (conf_cnt[i, j]) conf_cnt[i][j] = 0;
    class_cfg = NUM_CLASSES_RST;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(80, 6);
    test_random(80, 67);
    test_random(70, 0);
    wait_idle();
    if (err_cnt == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
